// ----- rtl/x86sd_pkg.sv -----
package x86sd_pkg;

  localparam int unsigned AddrWidthDef = 32;
  localparam logic [3:0] NoReg = 4'd8;

  // Mnemonic codes
  localparam logic [3:0] MnAdd  = 4'd0;
  localparam logic [3:0] MnPush = 4'd4;
  localparam logic [3:0] MnPop  = 4'd5;
  localparam logic [3:0] MnTest = 4'd6;
  localparam logic [3:0] MnMov  = 4'd7;
  localparam logic [3:0] MnJe   = 4'd8;
  localparam logic [3:0] MnSub  = 4'd9;
  localparam logic [3:0] MnCall = 4'd10;
  localparam logic [3:0] MnNd   = 4'd11;
  localparam logic [3:0] MnErr  = 4'd12;

  // Operand kinds
  localparam logic [2:0] KNone = 3'd0;
  localparam logic [2:0] KReg  = 3'd1;
  localparam logic [2:0] KMem  = 3'd2;
  localparam logic [2:0] KImm  = 3'd3;
  localparam logic [2:0] KSeg  = 3'd4;
  localparam logic [2:0] KRel  = 3'd5;

  // Opcodes with special handling
  localparam logic [7:0] OpJe    = 8'h74;
  localparam logic [7:0] OpSubIb = 8'h83;
  localparam logic [7:0] OpTest  = 8'h85;
  localparam logic [7:0] OpMovEG = 8'h89;
  localparam logic [7:0] OpMovGE = 8'h8B;
  localparam logic [7:0] OpMovMo = 8'hA1;
  localparam logic [7:0] OpMovIv = 8'hC7;
  localparam logic [7:0] OpGrp5  = 8'hFF;
  localparam logic [7:0] OpTwoB  = 8'h0F;
  localparam logic [7:0] OpOpsz  = 8'h66;

  typedef enum logic [4:0] {
    PH_OPC   = 5'b00001,
    PH_MODRM = 5'b00010,
    PH_SIB   = 5'b00100,
    PH_DISP  = 5'b01000,
    PH_IMM   = 5'b10000
  } phase_t;

  // Collected instruction bytes handed to the record builder
  typedef struct packed {
    logic [7:0]  opcode;
    logic [7:0]  modrm;
    logic [7:0]  sib;
    logic [31:0] disp;
    logic [31:0] imm;
    logic [31:0] addr;
    logic [3:0]  len;
    logic        bad;
  } instr_t;

  typedef struct packed {
    logic [3:0]  mnemonic;
    logic        operand_width;
    logic [2:0]  first_kind;
    logic [2:0]  second_kind;
    logic [2:0]  reg_number;
    logic [3:0]  base_reg;
    logic [3:0]  index_reg;
    logic [1:0]  scale_log2;
    logic [31:0] displacement;
    logic [31:0] operand_value;
    logic [3:0]  instr_length;
  } rec_t;

  function automatic logic has_modrm(input logic [7:0] op);
    if (op < 8'h20) return op[2:0] <= 3'd3;
    return op == OpSubIb || op == OpTest || op == OpMovEG || op == OpMovGE ||
           op == OpMovIv || op == OpGrp5;
  endfunction

  function automatic logic [2:0] imm_size(input logic [7:0] op);
    if (op < 8'h20) begin
      if (op[2:0] == 3'd4) return 3'd1;
      if (op[2:0] == 3'd5) return 3'd4;
      return 3'd0;
    end
    if (op == OpJe || op == OpSubIb) return 3'd1;
    if (op == OpMovIv || op == OpMovMo) return 3'd4;
    return 3'd0;
  endfunction

  function automatic logic [2:0] disp_size(input logic [7:0] modrm, input logic [7:0] sib);
    if (modrm[7:6] == 2'd1) return 3'd1;
    if (modrm[7:6] == 2'd2) return 3'd4;
    if (modrm[7:6] == 2'd0) begin
      if (modrm[2:0] == 3'd5) return 3'd4;
      if (modrm[2:0] == 3'd4 && sib[2:0] == 3'd5) return 3'd4;
    end
    return 3'd0;
  endfunction

endpackage

// ----- rtl/x86_instruction_subset_decoder.sv -----
// Channel | Ports                                   | Accepted when
// input   | in_code_byte, in_instr_address          | in_valid && in_ready
// result  | out_mnemonic ... out_instr_length       | out_valid && out_ready
//
// One code byte is taken per cycle while in_ready is high; a record leaves in the
// cycle after the instruction's last byte is taken, from a single output register.
// in_ready is low only while a record is held and out_ready is low.
// Reset (synchronous, rst_n low) returns to expecting an opcode byte.
module x86_instruction_subset_decoder #(
  parameter int unsigned ADDR_WIDTH = x86sd_pkg::AddrWidthDef
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_code_byte,
  input  logic [31:0] in_instr_address,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [3:0]  out_mnemonic,
  output logic        out_operand_width,
  output logic [2:0]  out_first_kind,
  output logic [2:0]  out_second_kind,
  output logic [2:0]  out_reg_number,
  output logic [3:0]  out_base_reg,
  output logic [3:0]  out_index_reg,
  output logic [1:0]  out_scale_log2,
  output logic signed [31:0] out_displacement,
  output logic [31:0] out_operand_value,
  output logic [3:0]  out_instr_length
);
  import x86sd_pkg::*;

  logic   acc, done;
  instr_t instr;
  rec_t   rec, rec_r;
  logic   valid_r;

  assign in_ready = !valid_r || out_ready;
  assign acc = in_valid && in_ready;

  x86sd_collect u_collect (
    .clk(clk), .rst_n(rst_n), .byte_valid(acc),
    .code_byte(in_code_byte), .instr_address(in_instr_address),
    .done(done), .instr(instr)
  );

  x86sd_build #(.ADDR_WIDTH(ADDR_WIDTH)) u_build (.instr(instr), .rec(rec));

  // Output register for the finished record.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= acc && done;
    end
  end

  always_ff @(posedge clk) begin
    if (acc && done) rec_r <= rec;
  end

  assign out_valid         = valid_r;
  assign out_mnemonic      = rec_r.mnemonic;
  assign out_operand_width = rec_r.operand_width;
  assign out_first_kind    = rec_r.first_kind;
  assign out_second_kind   = rec_r.second_kind;
  assign out_reg_number    = rec_r.reg_number;
  assign out_base_reg      = rec_r.base_reg;
  assign out_index_reg     = rec_r.index_reg;
  assign out_scale_log2    = rec_r.scale_log2;
  assign out_displacement  = rec_r.displacement;
  assign out_operand_value = rec_r.operand_value;
  assign out_instr_length  = rec_r.instr_length;

`ifndef SYNTHESIS
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_mnemonic))
    else $error("record dropped while stalled");
  a_stall_ready: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |-> !in_ready) else $error("item taken while record blocked");
  a_emit: assert property (@(posedge clk) disable iff (!rst_n)
    acc && done |=> out_valid) else $error("finished item not shown");
`endif

endmodule

// ----- rtl/x86sd_collect.sv -----
module x86sd_collect (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                byte_valid,
  input  logic [7:0]          code_byte,
  input  logic [31:0]         instr_address,
  output logic                done,
  output x86sd_pkg::instr_t   instr
);
  import x86sd_pkg::*;

  phase_t      phase_r, phase_nxt;
  logic [7:0]  op_r, op_nxt, modrm_r, modrm_nxt, sib_r, sib_nxt;
  logic [2:0]  cnt_r, cnt_nxt;
  logic [3:0]  len_r, len_nxt;
  logic [31:0] disp_r, disp_nxt, imm_r, imm_nxt, addr_r, addr_nxt;
  logic [2:0]  dsz, isz;
  logic        bad;
  logic [4:0]  sh;

  // Byte-serial collection of one instruction; done marks its last byte.
  always_comb begin
    phase_nxt = phase_r;
    op_nxt = op_r; modrm_nxt = modrm_r; sib_nxt = sib_r;
    cnt_nxt = cnt_r; len_nxt = len_r;
    disp_nxt = disp_r; imm_nxt = imm_r; addr_nxt = addr_r;
    done = 1'b0;
    bad = 1'b0;
    dsz = 3'd0;
    isz = 3'd0;
    sh = {cnt_r[1:0], 3'd0};
    if (byte_valid) begin
      case (phase_r)
        PH_OPC: begin
          addr_nxt = instr_address;
          op_nxt = code_byte;
          modrm_nxt = '0; sib_nxt = '0; disp_nxt = '0; imm_nxt = '0;
          len_nxt = 4'd1; cnt_nxt = 3'd0;
          isz = imm_size(code_byte);
          if (has_modrm(code_byte)) phase_nxt = PH_MODRM;
          else if (isz != 3'd0) phase_nxt = PH_IMM;
          else done = 1'b1;
        end
        PH_MODRM: begin
          len_nxt = len_r + 4'd1;
          modrm_nxt = code_byte;
          isz = imm_size(op_r);
          dsz = disp_size(code_byte, 8'd0);
          bad = (op_r == OpSubIb && code_byte[5:3] != 3'd5) ||
                (op_r == OpMovIv && code_byte[5:3] != 3'd0) ||
                (op_r == OpGrp5 && code_byte[5:3] != 3'd2);
          cnt_nxt = 3'd0;
          if (bad) done = 1'b1;
          else if (code_byte[7:6] != 2'd3 && code_byte[2:0] == 3'd4) phase_nxt = PH_SIB;
          else if (dsz != 3'd0) phase_nxt = PH_DISP;
          else if (isz != 3'd0) phase_nxt = PH_IMM;
          else done = 1'b1;
        end
        PH_SIB: begin
          len_nxt = len_r + 4'd1;
          sib_nxt = code_byte;
          isz = imm_size(op_r);
          dsz = disp_size(modrm_r, code_byte);
          cnt_nxt = 3'd0;
          if (dsz != 3'd0) phase_nxt = PH_DISP;
          else if (isz != 3'd0) phase_nxt = PH_IMM;
          else done = 1'b1;
        end
        PH_DISP: begin
          len_nxt = len_r + 4'd1;
          isz = imm_size(op_r);
          dsz = disp_size(modrm_r, sib_r);
          disp_nxt = disp_r | (32'(code_byte) << sh);
          cnt_nxt = cnt_r + 3'd1;
          if (cnt_nxt >= dsz) begin
            cnt_nxt = 3'd0;
            if (isz != 3'd0) phase_nxt = PH_IMM;
            else done = 1'b1;
          end
        end
        PH_IMM: begin
          len_nxt = len_r + 4'd1;
          isz = imm_size(op_r);
          imm_nxt = imm_r | (32'(code_byte) << sh);
          cnt_nxt = cnt_r + 3'd1;
          if (cnt_nxt >= isz) done = 1'b1;
        end
        default: phase_nxt = PH_OPC;
      endcase
      if (done) begin
        phase_nxt = PH_OPC;
        cnt_nxt = 3'd0;
      end
    end
  end

  // The record builder sees the bytes as they stand after this one.
  always_comb begin
    instr.opcode = op_nxt;
    instr.modrm  = modrm_nxt;
    instr.sib    = sib_nxt;
    instr.disp   = disp_nxt;
    instr.imm    = imm_nxt;
    instr.addr   = addr_nxt;
    instr.len    = len_nxt;
    instr.bad    = bad;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_OPC;
      op_r <= '0; modrm_r <= '0; sib_r <= '0;
      cnt_r <= '0; len_r <= '0;
      disp_r <= '0; imm_r <= '0; addr_r <= '0;
    end else begin
      phase_r <= phase_nxt;
      op_r <= op_nxt; modrm_r <= modrm_nxt; sib_r <= sib_nxt;
      cnt_r <= cnt_nxt; len_r <= len_nxt;
      disp_r <= disp_nxt; imm_r <= imm_nxt; addr_r <= addr_nxt;
    end
  end

`ifndef SYNTHESIS
  a_phase_onehot: assert property (@(posedge clk) disable iff (!rst_n) $onehot(phase_r))
    else $error("phase not one-hot");
  a_done_back_to_opc: assert property (@(posedge clk) disable iff (!rst_n)
    done |=> phase_r == PH_OPC) else $error("phase not back at opcode after done");
  a_len_range: assert property (@(posedge clk) disable iff (!rst_n)
    done |-> (instr.len >= 4'd1 && instr.len <= 4'd11)) else $error("length out of range");
`endif

endmodule

// ----- rtl/x86sd_build.sv -----
module x86sd_build #(
  parameter int unsigned ADDR_WIDTH = x86sd_pkg::AddrWidthDef
) (
  input  x86sd_pkg::instr_t instr,
  output x86sd_pkg::rec_t   rec
);
  import x86sd_pkg::*;

  localparam int unsigned TW = (ADDR_WIDTH > 33) ? ADDR_WIDTH : 33;

  logic [7:0]    op;
  logic [1:0]    md;
  logic [2:0]    rg, rm;
  logic [2:0]    dsz;
  logic [TW-1:0] tgt;
  logic [31:0]   ebx_disp;
  logic [2:0]    ekind;
  logic [3:0]    ebase, eidx;
  logic [1:0]    escale;

  assign op = instr.opcode;
  assign md = instr.modrm[7:6];
  assign rg = instr.modrm[5:3];
  assign rm = instr.modrm[2:0];

  // Effective-address part of the E operand.
  always_comb begin
    dsz = disp_size(instr.modrm, instr.sib);
    eidx = NoReg;
    escale = 2'd0;
    ebx_disp = '0;
    if (md == 2'd3) begin
      ekind = KReg;
      ebase = {1'b0, rm};
    end else begin
      ekind = KMem;
      if (rm == 3'd4) begin
        if (instr.sib[5:3] != 3'd4) begin
          eidx = {1'b0, instr.sib[5:3]};
          escale = instr.sib[7:6];
        end
        ebase = (md == 2'd0 && instr.sib[2:0] == 3'd5) ? NoReg : {1'b0, instr.sib[2:0]};
      end else if (md == 2'd0 && rm == 3'd5) begin
        ebase = NoReg;
      end else begin
        ebase = {1'b0, rm};
      end
      ebx_disp = (dsz == 3'd1) ? {{24{instr.disp[7]}}, instr.disp[7:0]} : instr.disp;
    end
  end

  // Short jump target, wrapped to the address width.
  always_comb begin
    tgt = TW'(instr.addr) + TW'(2) + TW'({{(TW-8){instr.imm[7]}}, instr.imm[7:0]});
    if (ADDR_WIDTH < TW) tgt = tgt & ((TW'(1) << ADDR_WIDTH) - TW'(1));
  end

  // Record assembly per opcode.
  always_comb begin
    rec = '0;
    rec.mnemonic = MnNd;
    rec.base_reg = NoReg;
    rec.index_reg = NoReg;
    rec.instr_length = instr.len;
    if (instr.bad) begin
      rec.mnemonic = MnErr;
    end else if (op < 8'h20) begin
      case (op[2:0])
        3'd0, 3'd1, 3'd2, 3'd3: begin
          rec.mnemonic = {1'b0, op[5:3]};
          rec.operand_width = op[0];
          rec.reg_number = rg;
          rec.base_reg = ebase; rec.index_reg = eidx;
          rec.scale_log2 = escale; rec.displacement = ebx_disp;
          if (op[1]) begin
            rec.first_kind = KReg; rec.second_kind = ekind;
          end else begin
            rec.first_kind = ekind; rec.second_kind = KReg;
          end
        end
        3'd4: begin
          rec.mnemonic = {1'b0, op[5:3]};
          rec.first_kind = KReg; rec.second_kind = KImm;
          rec.operand_value = {24'd0, instr.imm[7:0]};
        end
        3'd5: begin
          rec.mnemonic = {1'b0, op[5:3]}; rec.operand_width = 1'b1;
          rec.first_kind = KReg; rec.second_kind = KImm;
          rec.operand_value = instr.imm;
        end
        3'd6: begin
          rec.mnemonic = MnPush; rec.operand_width = 1'b1;
          rec.first_kind = KSeg; rec.reg_number = op[5:3];
        end
        default: begin
          if (op != OpTwoB) begin
            rec.mnemonic = MnPop; rec.operand_width = 1'b1;
            rec.first_kind = KSeg; rec.reg_number = op[5:3];
          end
        end
      endcase
    end else if (op[7:3] == 5'b01010) begin
      rec.mnemonic = MnPush; rec.operand_width = 1'b1;
      rec.first_kind = KReg; rec.reg_number = op[2:0];
    end else if (op == OpJe) begin
      rec.mnemonic = MnJe; rec.first_kind = KRel;
      rec.operand_value = tgt[31:0];
    end else if (op == OpSubIb) begin
      if (md == 2'd3) begin
        rec.mnemonic = MnSub; rec.operand_width = 1'b1;
        rec.first_kind = ekind; rec.base_reg = ebase;
        rec.second_kind = KImm;
        rec.operand_value = {{24{instr.imm[7]}}, instr.imm[7:0]};
      end
    end else if (op == OpTest || op == OpMovEG || op == OpMovGE) begin
      rec.mnemonic = (op == OpTest) ? MnTest : MnMov;
      rec.operand_width = 1'b1;
      rec.reg_number = rg;
      rec.base_reg = ebase; rec.index_reg = eidx;
      rec.scale_log2 = escale; rec.displacement = ebx_disp;
      if (op == OpMovGE) begin
        rec.first_kind = KReg; rec.second_kind = ekind;
      end else begin
        rec.first_kind = ekind; rec.second_kind = KReg;
      end
    end else if (op == OpMovMo) begin
      rec.mnemonic = MnMov; rec.operand_width = 1'b1;
      rec.first_kind = KReg; rec.second_kind = KMem;
      rec.displacement = instr.imm;
    end else if (op == OpMovIv) begin
      if (md <= 2'd1) begin
        rec.mnemonic = MnMov; rec.operand_width = 1'b1;
        rec.first_kind = ekind; rec.base_reg = ebase; rec.index_reg = eidx;
        rec.scale_log2 = escale; rec.displacement = ebx_disp;
        rec.second_kind = KImm; rec.operand_value = instr.imm;
      end
    end else if (op == OpGrp5) begin
      if (md == 2'd0 && rm == 3'd5) begin
        rec.mnemonic = MnCall; rec.operand_width = 1'b1;
        rec.first_kind = ekind; rec.base_reg = ebase; rec.index_reg = eidx;
        rec.scale_log2 = escale; rec.displacement = ebx_disp;
      end
    end else if (op != OpOpsz) begin
      rec.mnemonic = MnErr;
    end
  end

endmodule

// ----- sim/x86sd_checker.sv -----
module x86sd_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [7:0]  in_code_byte,
  input  logic [31:0] in_instr_address,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [3:0]  out_mnemonic,
  input  logic        out_operand_width,
  input  logic [2:0]  out_first_kind,
  input  logic [2:0]  out_second_kind,
  input  logic [2:0]  out_reg_number,
  input  logic [3:0]  out_base_reg,
  input  logic [3:0]  out_index_reg,
  input  logic [1:0]  out_scale_log2,
  input  logic signed [31:0] out_displacement,
  input  logic [31:0] out_operand_value,
  input  logic [3:0]  out_instr_length,
  output int          fail_count,
  output int          pending,
  output int          records_seen
);
  import x86sd_pkg::*;

  typedef enum logic [4:0] {
    WaitOpcode = 5'b00001,
    WaitModrm  = 5'b00010,
    WaitSib    = 5'b00100,
    WaitDisp   = 5'b01000,
    WaitImm    = 5'b10000
  } step_t;

  // Shadow decode state.
  step_t       step;
  logic [7:0]  cur_op, cur_modrm, cur_sib;
  logic [2:0]  byte_idx;
  logic [31:0] disp_acc, imm_acc, cur_addr;
  logic [3:0]  cur_len;

  rec_t decoded_q[$];

  function automatic logic takes_modrm(input logic [7:0] op);
    if (op < 8'h20) return op[2:0] <= 3'd3;
    return op == OpSubIb || op == OpTest || op == OpMovEG || op == OpMovGE ||
           op == OpMovIv || op == OpGrp5;
  endfunction

  function automatic int unsigned imm_bytes(input logic [7:0] op);
    if (op < 8'h20) return (op[2:0] == 3'd4) ? 1 : (op[2:0] == 3'd5) ? 4 : 0;
    if (op == OpJe || op == OpSubIb) return 1;
    if (op == OpMovIv || op == OpMovMo) return 4;
    return 0;
  endfunction

  function automatic int unsigned disp_bytes(input logic [7:0] m, input logic [7:0] s);
    if (m[7:6] == 2'd1) return 1;
    if (m[7:6] == 2'd2) return 4;
    if (m[7:6] == 2'd0 && (m[2:0] == 3'd5 || (m[2:0] == 3'd4 && s[2:0] == 3'd5))) return 4;
    return 0;
  endfunction

  function automatic rec_t unused_record(input logic [3:0] mn, input logic [3:0] len);
    rec_t r;
    r = '0;
    r.mnemonic = mn;
    r.base_reg = NoReg;
    r.index_reg = NoReg;
    r.instr_length = len;
    return r;
  endfunction

  // Memory or register operand described by the ModR/M and SIB bytes.
  function automatic rec_t with_rm(input rec_t r0, input bit first);
    rec_t r;
    r = r0;
    if (cur_modrm[7:6] == 2'd3) begin
      if (first) r.first_kind = KReg; else r.second_kind = KReg;
      r.base_reg = {1'b0, cur_modrm[2:0]};
      return r;
    end
    if (first) r.first_kind = KMem; else r.second_kind = KMem;
    if (cur_modrm[2:0] == 3'd4) begin
      if (cur_sib[5:3] != 3'd4) begin
        r.index_reg = {1'b0, cur_sib[5:3]};
        r.scale_log2 = cur_sib[7:6];
      end
      r.base_reg = (cur_modrm[7:6] == 2'd0 && cur_sib[2:0] == 3'd5) ?
                   NoReg : {1'b0, cur_sib[2:0]};
    end else if (cur_modrm[7:6] == 2'd0 && cur_modrm[2:0] == 3'd5) begin
      r.base_reg = NoReg;
    end else begin
      r.base_reg = {1'b0, cur_modrm[2:0]};
    end
    r.displacement = (disp_bytes(cur_modrm, cur_sib) == 1) ?
                     {{24{disp_acc[7]}}, disp_acc[7:0]} : disp_acc;
    return r;
  endfunction

  function automatic rec_t with_reg(input rec_t r0, input bit first);
    rec_t r;
    r = r0;
    if (first) r.first_kind = KReg; else r.second_kind = KReg;
    r.reg_number = cur_modrm[5:3];
    return r;
  endfunction

  // Record for a fully collected instruction.
  function automatic rec_t finished_record();
    rec_t r;
    logic [2:0] low;
    r = unused_record(MnNd, cur_len);
    low = cur_op[2:0];
    if (cur_op < 8'h20) begin
      if (low <= 3'd3) begin
        r.mnemonic = MnAdd + 4'(cur_op[4:3]);
        r.operand_width = cur_op[0];
        if (cur_op[1]) r = with_rm(with_reg(r, 1), 0);
        else r = with_reg(with_rm(r, 1), 0);
      end else if (low == 3'd4) begin
        r.mnemonic = MnAdd + 4'(cur_op[4:3]);
        r.first_kind = KReg; r.second_kind = KImm;
        r.operand_value = {24'd0, imm_acc[7:0]};
      end else if (low == 3'd5) begin
        r.mnemonic = MnAdd + 4'(cur_op[4:3]);
        r.operand_width = 1'b1;
        r.first_kind = KReg; r.second_kind = KImm;
        r.operand_value = imm_acc;
      end else if (low == 3'd6 || cur_op != OpTwoB) begin
        r.mnemonic = (low == 3'd6) ? MnPush : MnPop;
        r.operand_width = 1'b1;
        r.first_kind = KSeg;
        r.reg_number = {1'b0, cur_op[4:3]};
      end
      return r;
    end
    if (cur_op >= 8'h50 && cur_op <= 8'h57) begin
      r.mnemonic = MnPush; r.operand_width = 1'b1;
      r.first_kind = KReg; r.reg_number = cur_op[2:0];
    end else if (cur_op == OpJe) begin
      r.mnemonic = MnJe; r.first_kind = KRel;
      r.operand_value = cur_addr + 32'd2 + {{24{imm_acc[7]}}, imm_acc[7:0]};
    end else if (cur_op == OpSubIb) begin
      if (cur_modrm[7:6] == 2'd3) begin
        r.mnemonic = MnSub; r.operand_width = 1'b1;
        r = with_rm(r, 1);
        r.second_kind = KImm;
        r.operand_value = {{24{imm_acc[7]}}, imm_acc[7:0]};
      end
    end else if (cur_op == OpTest || cur_op == OpMovEG) begin
      r.mnemonic = (cur_op == OpTest) ? MnTest : MnMov;
      r.operand_width = 1'b1;
      r = with_reg(with_rm(r, 1), 0);
    end else if (cur_op == OpMovGE) begin
      r.mnemonic = MnMov; r.operand_width = 1'b1;
      r = with_rm(with_reg(r, 1), 0);
    end else if (cur_op == OpMovMo) begin
      r.mnemonic = MnMov; r.operand_width = 1'b1;
      r.first_kind = KReg; r.second_kind = KMem;
      r.displacement = imm_acc;
    end else if (cur_op == OpMovIv) begin
      if (cur_modrm[7:6] <= 2'd1) begin
        r.mnemonic = MnMov; r.operand_width = 1'b1;
        r = with_rm(r, 1);
        r.second_kind = KImm;
        r.operand_value = imm_acc;
      end
    end else if (cur_op == OpGrp5) begin
      if (cur_modrm[7:6] == 2'd0 && cur_modrm[2:0] == 3'd5) begin
        r.mnemonic = MnCall; r.operand_width = 1'b1;
        r = with_rm(r, 1);
      end
    end else if (cur_op != OpOpsz) begin
      r.mnemonic = MnErr;
    end
    return r;
  endfunction

  // After opcode, ModR/M and SIB: go on to displacement or immediate, or finish.
  function automatic bit addressing_done();
    byte_idx = 3'd0;
    if (takes_modrm(cur_op) && disp_bytes(cur_modrm, cur_sib) != 0) begin
      step = WaitDisp;
      return 1'b0;
    end
    if (imm_bytes(cur_op) != 0) begin
      step = WaitImm;
      return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic bit bad_extension();
    return (cur_op == OpSubIb && cur_modrm[5:3] != 3'd5) ||
           (cur_op == OpMovIv && cur_modrm[5:3] != 3'd0) ||
           (cur_op == OpGrp5 && cur_modrm[5:3] != 3'd2);
  endfunction

  // Advance the shadow decoder by one code byte.
  task automatic decode_byte(input logic [7:0] b, input logic [31:0] a);
    bit done;
    done = 1'b0;
    if (step == WaitOpcode) begin
      cur_addr = a;
      cur_op = b;
      cur_modrm = '0; cur_sib = '0;
      disp_acc = '0; imm_acc = '0;
      cur_len = 4'd1;
      if (takes_modrm(b)) step = WaitModrm;
      else done = addressing_done();
    end else begin
      cur_len = cur_len + 4'd1;
      case (step)
        WaitModrm: begin
          cur_modrm = b;
          if (bad_extension()) begin
            decoded_q.push_back(unused_record(MnErr, cur_len));
            step = WaitOpcode;
            return;
          end
          if (cur_modrm[7:6] != 2'd3 && cur_modrm[2:0] == 3'd4) step = WaitSib;
          else done = addressing_done();
        end
        WaitSib: begin
          cur_sib = b;
          done = addressing_done();
        end
        WaitDisp: begin
          disp_acc = disp_acc | (32'(b) << (8 * byte_idx[1:0]));
          byte_idx = byte_idx + 3'd1;
          if (byte_idx >= disp_bytes(cur_modrm, cur_sib)) begin
            byte_idx = 3'd0;
            if (imm_bytes(cur_op) != 0) step = WaitImm;
            else done = 1'b1;
          end
        end
        default: begin
          imm_acc = imm_acc | (32'(b) << (8 * byte_idx[1:0]));
          byte_idx = byte_idx + 3'd1;
          if (byte_idx >= imm_bytes(cur_op)) done = 1'b1;
        end
      endcase
    end
    if (done) begin
      decoded_q.push_back(finished_record());
      step = WaitOpcode;
      byte_idx = 3'd0;
    end
  endtask

  task automatic report_mismatch(input string field, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("MISMATCH record %0d %s: got 0x%0h, expected 0x%0h",
             records_seen, field, got, want);
    fail_count++;
  endtask

  task automatic compare_field(input string field, input logic [31:0] got,
                               input logic [31:0] want);
    if (got !== want) report_mismatch(field, got, want);
  endtask

  // Results are checked before the byte of the same edge is predicted, since a
  // record is registered and leaves only after the edge that takes its last byte.
  always @(posedge clk) begin
    rec_t e;
    if (!rst_n) begin
      step = WaitOpcode;
      cur_op = '0; cur_modrm = '0; cur_sib = '0; byte_idx = '0;
      disp_acc = '0; imm_acc = '0; cur_addr = '0; cur_len = '0;
      decoded_q.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (decoded_q.size() == 0) begin
          report_mismatch("unexpected record", 32'(out_mnemonic), 32'd0);
        end else begin
          e = decoded_q.pop_front();
          compare_field("mnemonic", 32'(out_mnemonic), 32'(e.mnemonic));
          compare_field("operand_width", 32'(out_operand_width), 32'(e.operand_width));
          compare_field("first_kind", 32'(out_first_kind), 32'(e.first_kind));
          compare_field("second_kind", 32'(out_second_kind), 32'(e.second_kind));
          compare_field("reg_number", 32'(out_reg_number), 32'(e.reg_number));
          compare_field("base_reg", 32'(out_base_reg), 32'(e.base_reg));
          compare_field("index_reg", 32'(out_index_reg), 32'(e.index_reg));
          compare_field("scale_log2", 32'(out_scale_log2), 32'(e.scale_log2));
          compare_field("displacement", out_displacement, e.displacement);
          compare_field("operand_value", out_operand_value, e.operand_value);
          compare_field("instr_length", 32'(out_instr_length), 32'(e.instr_length));
        end
        records_seen++;
      end
      if (in_valid && in_ready) decode_byte(in_code_byte, in_instr_address);
    end
    pending = decoded_q.size();
  end

endmodule

// ----- sim/tb_x86_instruction_subset_decoder.sv -----
module tb_x86_instruction_subset_decoder;
  import x86sd_pkg::*;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  in_code_byte = '0;
  logic [31:0] in_instr_address = '0;
  logic        out_valid;
  logic        out_ready = 1'b1;
  logic [3:0]  out_mnemonic;
  logic        out_operand_width;
  logic [2:0]  out_first_kind;
  logic [2:0]  out_second_kind;
  logic [2:0]  out_reg_number;
  logic [3:0]  out_base_reg;
  logic [3:0]  out_index_reg;
  logic [1:0]  out_scale_log2;
  logic signed [31:0] out_displacement;
  logic [31:0] out_operand_value;
  logic [3:0]  out_instr_length;

  int fail_count, pending, records_seen;
  int bytes_sent = 0;
  bit idle_on = 1'b0;
  int stall_left = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  x86_instruction_subset_decoder DUT (.*);

  x86sd_checker u_checker (.*);

  // Result side: random stall bursts while idling is enabled.
  always @(negedge clk) begin
    if (stall_left > 0) begin
      out_ready <= 1'b0;
      stall_left--;
    end else if (idle_on && $urandom_range(0, 11) == 0) begin
      out_ready <= 1'b0;
      stall_left = $urandom_range(0, 18);
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Present one code byte and hold it until accepted; returns at a falling edge.
  task automatic send_byte(input logic [7:0] b, input logic [31:0] a);
    if (idle_on && $urandom_range(0, 9) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_code_byte <= b;
    in_instr_address <= a;
    do @(posedge clk); while (!in_ready);
    bytes_sent++;
    @(negedge clk);
  endtask

  task automatic send_instr(input logic [7:0] seq[$], input logic [31:0] a);
    foreach (seq[i]) send_byte(seq[i], a);
  endtask

  // Build one instruction with random content; most are well-formed.
  task automatic make_instr(output logic [7:0] seq[$]);
    logic [7:0] covered[12] = '{8'h01, 8'h8B, OpJe, OpSubIb, OpTest, OpMovEG,
                                OpMovGE, OpMovMo, OpMovIv, OpGrp5, 8'h52, 8'h15};
    logic [7:0] op, modrm, sib;
    int pick, nd, ni;
    bit bad;
    pick = $urandom_range(0, 99);
    if (pick < 65) op = covered[$urandom_range(0, 11)];
    else if (pick < 88) op = 8'($urandom_range(0, 31));
    else op = 8'($urandom);
    if (op == 8'h01 || op == 8'h15 || op == 8'h52) op = op ^ 8'($urandom_range(0, 7));
    seq = '{op};
    modrm = 8'($urandom);
    sib = 8'($urandom);
    // Mostly the valid extension for the group opcodes.
    if ($urandom_range(0, 4) != 0) begin
      if (op == OpSubIb) modrm = {2'd3, 3'd5, modrm[2:0]};
      if (op == OpMovIv) modrm = {1'b0, modrm[6], 3'd0, modrm[2:0]};
      if (op == OpGrp5) modrm = {2'd0, 3'd2, 3'd5};
    end
    if (op < 8'h20) ni = (op[2:0] == 3'd4) ? 1 : (op[2:0] == 3'd5) ? 4 : 0;
    else if (op == OpJe || op == OpSubIb) ni = 1;
    else if (op == OpMovIv || op == OpMovMo) ni = 4;
    else ni = 0;
    if ((op < 8'h20 && op[2:0] <= 3'd3) || op == OpSubIb || op == OpTest ||
        op == OpMovEG || op == OpMovGE || op == OpMovIv || op == OpGrp5) begin
      seq.push_back(modrm);
      bad = (op == OpSubIb && modrm[5:3] != 3'd5) ||
            (op == OpMovIv && modrm[5:3] != 3'd0) ||
            (op == OpGrp5 && modrm[5:3] != 3'd2);
      if (bad) return;
      if (modrm[7:6] != 2'd3 && modrm[2:0] == 3'd4) seq.push_back(sib);
      nd = (modrm[7:6] == 2'd1) ? 1 : (modrm[7:6] == 2'd2) ? 4 :
           (modrm[7:6] == 2'd0 && (modrm[2:0] == 3'd5 ||
            (modrm[2:0] == 3'd4 && sib[2:0] == 3'd5))) ? 4 : 0;
      repeat (nd) seq.push_back(8'($urandom));
    end
    repeat (ni) seq.push_back(8'($urandom));
  endtask

  initial begin
    logic [7:0] seq[$];
    logic [31:0] addr;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: each opcode family, addressing corners and error forms.
    send_instr('{8'h00, 8'hC0}, 32'h0);
    send_instr('{8'h03, 8'h04, 8'h25, 8'h78, 8'h56, 8'h34, 8'h12}, 32'h1000);
    send_instr('{8'h0A, 8'h44, 8'hE3, 8'h80}, 32'h1000);
    send_instr('{8'h04, 8'hFF}, 32'hFFFF_FFFF);
    send_instr('{8'h1D, 8'hFF, 8'hFF, 8'hFF, 8'hFF}, 32'h0);
    send_instr('{8'h06}, 32'h0);
    send_instr('{8'h1F}, 32'h0);
    send_instr('{OpTwoB}, 32'h0);
    send_instr('{OpOpsz}, 32'h0);
    send_instr('{8'h57}, 32'h0);
    send_instr('{8'hF4}, 32'h0);
    send_instr('{OpJe, 8'h7F}, 32'hFFFF_FFFF);
    send_instr('{OpJe, 8'h80}, 32'h0);
    send_instr('{OpSubIb, 8'hEB, 8'h80}, 32'h0);
    send_instr('{OpSubIb, 8'h68, 8'h10, 8'h01}, 32'h0);
    send_instr('{OpSubIb, 8'hC0}, 32'h0);
    send_instr('{OpTest, 8'h44, 8'h24, 8'hF0}, 32'h0);
    send_instr('{OpMovEG, 8'hBF, 8'h00, 8'h00, 8'h00, 8'h80}, 32'h0);
    send_instr('{OpMovGE, 8'h14, 8'hCD, 8'hFF, 8'hFF, 8'hFF, 8'h7F}, 32'h0);
    send_instr('{OpMovMo, 8'h01, 8'h02, 8'h03, 8'h04}, 32'h0);
    send_instr('{OpMovIv, 8'h04, 8'h25, 8'h11, 8'h22, 8'h33, 8'h44,
                 8'hAA, 8'hBB, 8'hCC, 8'hDD}, 32'h0);
    send_instr('{OpMovIv, 8'h80, 8'h1, 8'h2, 8'h3, 8'h4, 8'h5, 8'h6, 8'h7, 8'h8}, 32'h0);
    send_instr('{OpMovIv, 8'h08}, 32'h0);
    send_instr('{OpGrp5, 8'h15, 8'hEF, 8'hBE, 8'hAD, 8'hDE}, 32'h0);
    send_instr('{OpGrp5, 8'h10}, 32'h0);
    send_instr('{OpGrp5, 8'h00}, 32'h0);

    // Random: mostly well-formed instructions, some stray bytes.
    idle_on = 1'b1;
    while (bytes_sent < 1450) begin
      if (bytes_sent > 1250) idle_on = 1'b0;
      case ($urandom_range(0, 3))
        0: addr = 32'hFFFF_FFFF - 32'($urandom_range(0, 200));
        1: addr = 32'($urandom_range(0, 200));
        default: addr = $urandom;
      endcase
      if ($urandom_range(0, 19) == 0) seq = '{8'($urandom), 8'($urandom)};
      else make_instr(seq);
      send_instr(seq, addr);
    end
    in_valid <= 1'b0;
    idle_on = 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    $display("Sent %0d code bytes of directed and random instructions, %0d records checked.",
             bytes_sent, records_seen);
    if (fail_count == 0 && pending == 0) begin
      $display("x86_instruction_subset_decoder verification clean");
    end else begin
      $display("x86_instruction_subset_decoder verification failed");
    end
    $finish;
  end

  // Watchdog for a stuck handshake.
  initial begin
    #5000000;
    $display("Timeout with %0d records outstanding.", pending);
    $display("x86_instruction_subset_decoder verification failed");
    $finish;
  end

endmodule
